[hdl/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion helpers for the page allocator; define ASSERT_OFF to drop them.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
// Property checked on every clock edge outside reset.
`define BPA_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");
// Condition in one cycle forces a consequence in the next.
`define BPA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define BPA_ASSERT(label, clk, rst_n, prop)
`define BPA_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

[hdl/bpa_pkg.sv]
// ----------------------------------------------------------------------------
// bpa_pkg
// Shared types, codes and helpers of the bitmap page allocator.
// ----------------------------------------------------------------------------
package bpa_pkg;

  // Used map word geometry
  localparam int WORD_BITS = 64;
  localparam int BIT_W     = 6;

  // Configuration fields
  localparam int ADDR_W      = 64;
  localparam int PCOUNT_W    = 13;
  localparam int PADDR_W     = 4;
  localparam int REG_SEL_BIT = 3;

  // Register select (byte address bit 3)
  localparam logic REG_RAM_BASE    = 1'b0;
  localparam logic REG_FRAME_LIMIT = 1'b1;

  // Request opcodes
  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_EXHAUSTED = 2'd1,
    ST_NULL      = 2'd2,
    ST_RANGE     = 2'd3
  } status_t;

  typedef struct packed {
    logic [ADDR_W-1:0]   ram_base;
    logic [PCOUNT_W-1:0] frame_limit;
  } cfg_t;

  // Lowest clear bit of a word; all ones returns the top bit index.
  function automatic logic [BIT_W-1:0] lowest_clear(input logic [WORD_BITS-1:0] w);
    logic [BIT_W-1:0] b;
    b = BIT_W'(WORD_BITS - 1);
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (!w[i]) begin
        b = BIT_W'(i);
      end
    end
    return b;
  endfunction

endpackage

[hdl/bpa_ram.sv]
// ----------------------------------------------------------------------------
// bpa_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module bpa_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                        wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

[hdl/bpa_addsub.sv]
// ----------------------------------------------------------------------------
// bpa_addsub
// Shared 64-bit adder/subtractor with borrow, used for address math.
// ----------------------------------------------------------------------------
module bpa_addsub (
  input  logic [bpa_pkg::ADDR_W-1:0] a,
  input  logic [bpa_pkg::ADDR_W-1:0] b,
  input  logic                       sub,
  output logic [bpa_pkg::ADDR_W-1:0] sum,
  output logic                       borrow
);
  import bpa_pkg::*;

  logic [ADDR_W:0]   total;
  logic [ADDR_W-1:0] b_op;

  // Subtract as a plus inverted b plus one; borrow is the missing carry
  assign b_op   = sub ? ~b : b;
  assign total  = {1'b0, a} + {1'b0, b_op} + {{ADDR_W{1'b0}}, sub};
  assign sum    = total[ADDR_W-1:0];
  assign borrow = sub & ~total[ADDR_W];

endmodule

[hdl/bpa_cfg.sv]
// ----------------------------------------------------------------------------
// bpa_cfg
// APB register file holding the managed range (ram base, page count).
// ----------------------------------------------------------------------------
module bpa_cfg (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [bpa_pkg::PADDR_W-1:0] paddr,
  input  logic [63:0]                 pwdata,
  output logic [63:0]                 prdata,
  output logic                        pready,
  output bpa_pkg::cfg_t               cfg
);
  import bpa_pkg::*;

  logic [ADDR_W-1:0]   ram_base_r;
  logic [PCOUNT_W-1:0] frame_limit_r;
  logic                wr_en;
  logic                reg_sel;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite & pready;
  assign reg_sel = paddr[REG_SEL_BIT];

  // Register writes on the access phase
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ram_base_r    <= '0;
      frame_limit_r <= '0;
    end else if (wr_en) begin
      case (reg_sel)
        REG_RAM_BASE:    ram_base_r    <= pwdata;
        REG_FRAME_LIMIT: frame_limit_r <= pwdata[PCOUNT_W-1:0];
        default: ;
      endcase
    end
  end

  // Read back
  always_comb begin
    case (reg_sel)
      REG_RAM_BASE:    prdata = ram_base_r;
      REG_FRAME_LIMIT: prdata = 64'(frame_limit_r);
      default:         prdata = '0;
    endcase
  end

  assign cfg.ram_base    = ram_base_r;
  assign cfg.frame_limit = frame_limit_r;

endmodule

[hdl/bitmap_page_allocator_top.sv]
// ----------------------------------------------------------------------------
// bitmap_page_allocator_top
// Page frame allocator over a one-bit-per-page used map held in RAM words.
//
//   channel  ports                                   handshake
//   cfg      psel penable pwrite paddr pwdata prdata  APB, pready tied high
//   in       start in_op in_page_addr                 taken when start & !busy
//   out      out_valid out_status out_result_addr     one-cycle strobe
//
// Allocate: scan of k used-map words (1 .. NUM_PAGES/64), then address add;
//   the scan reads one 64-bit word per cycle from the map RAM's read port.
//   When no page is free the reply comes from the scan, with no address add.
// Free: subtract, range check and read, write back; an out of range free
//   replies from the range check, a null free straight from idle.
// After reset a fill pass writes all ones over NUM_PAGES/64 words, busy high.
// Results cannot be stalled; a new request is taken while out_valid shows.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module bitmap_page_allocator_top #(
  parameter int NUM_PAGES  = 4096,
  parameter int PAGE_BYTES = 4096
) (
  input  logic                        clk,
  input  logic                        rst_n,
  // configuration
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [bpa_pkg::PADDR_W-1:0] paddr,
  input  logic [63:0]                 pwdata,
  output logic [63:0]                 prdata,
  output logic                        pready,
  // request
  input  logic                        start,
  output logic                        busy,
  input  logic                        in_op,
  input  logic [63:0]                 in_page_addr,
  // result
  output logic                        out_valid,
  output logic [1:0]                  out_status,
  output logic [63:0]                 out_result_addr
);
  import bpa_pkg::*;

  localparam int MAP_WORDS = (NUM_PAGES + WORD_BITS - 1) / WORD_BITS;
  localparam int WW        = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
  localparam int PIW       = WW + BIT_W;
  localparam int SHIFT     = $clog2(PAGE_BYTES);
  localparam int NPW       = $clog2(NUM_PAGES + 1);
  localparam int LW        = (NPW > PCOUNT_W) ? NPW : PCOUNT_W;
  localparam int CW        = (PIW > LW) ? PIW : LW;

  typedef enum logic [6:0] {
    S_INIT = 7'b0000001,
    S_IDLE = 7'b0000010,
    S_ACHK = 7'b0000100,
    S_AADD = 7'b0001000,
    S_FSUB = 7'b0010000,
    S_FCHK = 7'b0100000,
    S_FWR  = 7'b1000000
  } state_t;

  state_t            state_r, state_nxt;
  logic [WW-1:0]     w_r, w_nxt;
  logic [PIW-1:0]    idx_r, idx_nxt;
  logic [ADDR_W-1:0] addr_r, addr_nxt;
  logic [ADDR_W-1:0] off_r, off_nxt;
  logic              borrow_r, borrow_nxt;
  logic              out_valid_r, out_valid_nxt;
  status_t           out_status_r, out_status_nxt;
  logic [ADDR_W-1:0] out_addr_r, out_addr_nxt;

  cfg_t              cfg;
  logic [LW-1:0]     limit;
  logic [LW-1:0]     pc_ext;

  logic              ram_we;
  logic [WW-1:0]     ram_waddr;
  logic [WORD_BITS-1:0] ram_wdata;
  logic [WW-1:0]     ram_raddr;
  logic [WORD_BITS-1:0] ram_rdata;

  logic [ADDR_W-1:0] alu_a, alu_b, alu_sum;
  logic              alu_sub, alu_borrow;

  logic [BIT_W-1:0]  free_bit;
  logic [PIW-1:0]    word_base;
  logic [PIW-1:0]    cand_idx;
  logic              word_full;
  logic              last_word;
  logic [PIW-1:0]    free_idx;
  logic              free_hi_nz;
  logic              free_oor;

  // Configuration registers
  bpa_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Used map storage, one 64-bit word per entry
  bpa_ram #(
    .WIDTH (WORD_BITS),
    .DEPTH (MAP_WORDS)
  ) u_map (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Shared address adder: base plus page offset, or free address minus base
  bpa_addsub u_alu (
    .a      (alu_a),
    .b      (alu_b),
    .sub    (alu_sub),
    .sum    (alu_sum),
    .borrow (alu_borrow)
  );

  always_comb begin
    if (state_r == S_AADD) begin
      alu_a   = cfg.ram_base;
      alu_b   = ADDR_W'(idx_r) << SHIFT;
      alu_sub = 1'b0;
    end else begin
      alu_a   = addr_r;
      alu_b   = cfg.ram_base;
      alu_sub = 1'b1;
    end
  end

  // Clamp the page count to the map depth
  assign pc_ext = LW'(cfg.frame_limit);
  assign limit  = (pc_ext > LW'(NUM_PAGES)) ? LW'(NUM_PAGES) : pc_ext;

  // Scan word decode
  assign free_bit  = lowest_clear(ram_rdata);
  assign word_base = {w_r, {BIT_W{1'b0}}};
  assign cand_idx  = {w_r, free_bit};
  assign word_full = &ram_rdata;
  assign last_word = (w_r == WW'(MAP_WORDS - 1));

  // Free address decode from the registered offset
  assign free_idx   = off_r[SHIFT +: PIW];
  assign free_hi_nz = |(off_r >> (SHIFT + PIW));
  assign free_oor   = borrow_r | free_hi_nz | (CW'(free_idx) >= CW'(limit));

  // Sequencer
  always_comb begin
    state_nxt      = state_r;
    w_nxt          = w_r;
    idx_nxt        = idx_r;
    addr_nxt       = addr_r;
    off_nxt        = off_r;
    borrow_nxt     = borrow_r;
    out_valid_nxt  = 1'b0;
    out_status_nxt = out_status_r;
    out_addr_nxt   = out_addr_r;
    ram_we         = 1'b0;
    ram_waddr      = w_r;
    ram_wdata      = '1;
    ram_raddr      = '0;

    case (state_r)
      S_INIT: begin
        // Fill pass: mark every page used
        ram_we = 1'b1;
        if (last_word) begin
          w_nxt     = '0;
          state_nxt = S_IDLE;
        end else begin
          w_nxt = w_r + 1'b1;
        end
      end

      S_IDLE: begin
        // Word 0 is read here so the scan starts on the next cycle
        w_nxt = '0;
        if (start) begin
          if (in_op == OP_ALLOC) begin
            state_nxt = S_ACHK;
          end else if (in_page_addr == '0) begin
            out_valid_nxt  = 1'b1;
            out_status_nxt = ST_NULL;
            out_addr_nxt   = '0;
          end else begin
            addr_nxt  = in_page_addr;
            state_nxt = S_FSUB;
          end
        end
      end

      S_ACHK: begin
        // Prefetch the next word while this one is checked
        ram_raddr = last_word ? w_r : w_r + 1'b1;
        if (CW'(word_base) >= CW'(limit)) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = ST_EXHAUSTED;
          out_addr_nxt   = '0;
          state_nxt      = S_IDLE;
        end else if (word_full) begin
          if (last_word) begin
            out_valid_nxt  = 1'b1;
            out_status_nxt = ST_EXHAUSTED;
            out_addr_nxt   = '0;
            state_nxt      = S_IDLE;
          end else begin
            w_nxt = w_r + 1'b1;
          end
        end else if (CW'(cand_idx) >= CW'(limit)) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = ST_EXHAUSTED;
          out_addr_nxt   = '0;
          state_nxt      = S_IDLE;
        end else begin
          ram_we    = 1'b1;
          ram_waddr = w_r;
          ram_wdata = ram_rdata | (WORD_BITS'(1) << free_bit);
          idx_nxt   = cand_idx;
          state_nxt = S_AADD;
        end
      end

      S_AADD: begin
        out_valid_nxt  = 1'b1;
        out_status_nxt = ST_OK;
        out_addr_nxt   = alu_sum;
        state_nxt      = S_IDLE;
      end

      S_FSUB: begin
        off_nxt    = alu_sum;
        borrow_nxt = alu_borrow;
        state_nxt  = S_FCHK;
      end

      S_FCHK: begin
        // Reject out-of-range frees, else fetch the word holding the page
        ram_raddr = free_idx[PIW-1:BIT_W];
        if (free_oor) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = ST_RANGE;
          out_addr_nxt   = '0;
          state_nxt      = S_IDLE;
        end else begin
          idx_nxt   = free_idx;
          state_nxt = S_FWR;
        end
      end

      S_FWR: begin
        // Clear the page bit and write the word back
        ram_we         = 1'b1;
        ram_waddr      = idx_r[PIW-1:BIT_W];
        ram_wdata      = ram_rdata & ~(WORD_BITS'(1) << idx_r[BIT_W-1:0]);
        out_valid_nxt  = 1'b1;
        out_status_nxt = ST_OK;
        out_addr_nxt   = '0;
        state_nxt      = S_IDLE;
      end

      default: begin
        state_nxt = S_INIT;
        w_nxt     = '0;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_INIT;
      w_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      w_r         <= w_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    idx_r        <= idx_nxt;
    addr_r       <= addr_nxt;
    off_r        <= off_nxt;
    borrow_r     <= borrow_nxt;
    out_status_r <= out_status_nxt;
    out_addr_r   <= out_addr_nxt;
  end

  assign busy            = (state_r != S_IDLE);
  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_result_addr = out_addr_r;

  // An allocate request always enters the word scan
  `BPA_ASSERT_NEXT(a_alloc_scans, clk, rst_n, start && !busy && in_op == OP_ALLOC, state_r == S_ACHK)
  // Only a successful allocate carries an address
  `BPA_ASSERT(a_addr_zero, clk, rst_n, !(out_valid && out_status != ST_OK) || out_result_addr == '0)
  // A result is shown only once the sequencer is back in idle
  `BPA_ASSERT(a_valid_idle, clk, rst_n, !out_valid || !busy)

endmodule

[dv/tb.sv]
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the bitmap page allocator. Requests go in on the
// start/busy handshake and the configuration goes through the APB port. A
// local used-map model predicts each reply. Every reply strobe is checked
// against the oldest prediction. Directed cases come first, then random
// traffic under several page-count and base-address settings.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import bpa_pkg::*;

  localparam int          NUM_PAGES    = 4096;
  localparam int          PAGE_BYTES   = 4096;
  localparam int          RESET_CYCLES = 11;
  localparam int          DRAIN_CYCLES = 80;
  localparam int unsigned PHASE_ITEMS  = 300;
  localparam longint      CYCLE_LIMIT  = 1_000_000;

  localparam logic [PADDR_W-1:0] RAM_BASE_ADDR    = PADDR_W'(REG_RAM_BASE) << REG_SEL_BIT;
  localparam logic [PADDR_W-1:0] FRAME_LIMIT_ADDR = PADDR_W'(REG_FRAME_LIMIT) << REG_SEL_BIT;

  typedef struct {
    status_t     status;
    logic [63:0] addr;
  } page_reply_t;

  logic                clk;
  logic                rst_n;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [PADDR_W-1:0]  paddr;
  logic [63:0]         pwdata;
  logic [63:0]         prdata;
  logic                pready;
  logic                start;
  logic                busy;
  logic                in_op;
  logic [63:0]         in_page_addr;
  logic                out_valid;
  logic [1:0]          out_status;
  logic [63:0]         out_result_addr;

  // Local copy of the allocator state and registers
  bit                  frame_used [NUM_PAGES];
  logic [63:0]         model_base;
  logic [PCOUNT_W-1:0] model_count;

  page_reply_t         expected_replies [$];
  page_reply_t         oldest_reply;
  int unsigned         mismatches;
  int unsigned         requests_sent;
  int unsigned         status_seen [4];
  longint              cycle_count;

  bitmap_page_allocator_top #(
    .NUM_PAGES (NUM_PAGES),
    .PAGE_BYTES(PAGE_BYTES)
  ) u_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .start          (start),
    .busy           (busy),
    .in_op          (in_op),
    .in_page_addr   (in_page_addr),
    .out_valid      (out_valid),
    .out_status     (out_status),
    .out_result_addr(out_result_addr)
  );

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d replies outstanding", cycle_count,
               expected_replies.size());
      $display("tb: FAIL");
      $finish;
    end
  end

  // Page count in effect, clamped to the map depth
  function automatic int unsigned managed_frames();
    return (model_count > NUM_PAGES) ? NUM_PAGES : int'(model_count);
  endfunction

  // Apply one request to the local map and return the reply it must produce
  function automatic page_reply_t predict_page_request(logic op, logic [63:0] addr);
    page_reply_t r;
    int unsigned lim;
    logic [63:0] idx;
    r.status = ST_EXHAUSTED;
    r.addr   = '0;
    lim      = managed_frames();
    if (op == OP_ALLOC) begin
      for (int i = 0; i < lim; i++) begin
        if (!frame_used[i]) begin
          frame_used[i] = 1'b1;
          r.status = ST_OK;
          r.addr   = model_base + 64'(i) * 64'(PAGE_BYTES);
          return r;
        end
      end
    end else if (addr == '0) begin
      r.status = ST_NULL;
    end else if (addr < model_base) begin
      r.status = ST_RANGE;
    end else begin
      idx = (addr - model_base) / 64'(PAGE_BYTES);
      if (idx >= 64'(lim)) begin
        r.status = ST_RANGE;
      end else begin
        frame_used[idx] = 1'b0;
        r.status = ST_OK;
      end
    end
    return r;
  endfunction

  // Compare every reply strobe with the oldest prediction
  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1) begin
      if (expected_replies.size() == 0) begin
        $error("reply with none outstanding: out_status %0d out_result_addr %h",
               out_status, out_result_addr);
        mismatches++;
      end else begin
        oldest_reply = expected_replies.pop_front();
        status_seen[oldest_reply.status]++;
        if (out_status !== oldest_reply.status) begin
          $error("out_status: expected %0d, got %0d", oldest_reply.status, out_status);
          mismatches++;
        end
        if (out_result_addr !== oldest_reply.addr) begin
          $error("out_result_addr: expected %h, got %h", oldest_reply.addr,
                 out_result_addr);
          mismatches++;
        end
      end
    end
  end

  // Present one request and hold it until taken; start stays high on return
  task automatic send_request(logic op, logic [63:0] addr);
    @(negedge clk);
    start        = 1'b1;
    in_op        = op;
    in_page_addr = addr;
    @(posedge clk);
    while (busy !== 1'b0) @(posedge clk);
    expected_replies.push_back(predict_page_request(op, addr));
    requests_sent++;
  endtask

  // Drop start and idle for a while
  task automatic hold_off(int unsigned n);
    @(negedge clk);
    start = 1'b0;
    repeat (n) @(negedge clk);
  endtask

  // Stop sending and wait until every reply is back and the block is idle
  task automatic drain_replies();
    hold_off(0);
    while (expected_replies.size() != 0) @(posedge clk);
    while (busy !== 1'b0) @(posedge clk);
  endtask

  // APB write: setup cycle, then access cycle
  task automatic write_register(logic [PADDR_W-1:0] reg_addr, logic [63:0] value);
    @(negedge clk);
    start   = 1'b0;
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = reg_addr;
    pwdata  = value;
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    while (pready !== 1'b1) @(posedge clk);
    if (reg_addr == RAM_BASE_ADDR) begin
      model_base = value;
    end else begin
      model_count = value[PCOUNT_W-1:0];
    end
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  task automatic configure(logic [63:0] base, logic [PCOUNT_W-1:0] count);
    drain_replies();
    write_register(RAM_BASE_ADDR, base);
    write_register(FRAME_LIMIT_ADDR, 64'(count));
  endtask

  // Mostly allocates and in-range frees, some null and out-of-range noise
  task automatic send_random_request();
    logic        op;
    logic [63:0] addr;
    int unsigned lim;
    int unsigned pick;
    lim  = managed_frames();
    pick = $urandom_range(0, 99);
    addr = {$urandom, $urandom};
    op   = OP_FREE;
    if (pick < 45) begin
      op = OP_ALLOC;
    end else if (pick < 82 && lim > 0) begin
      addr = model_base + 64'($urandom_range(0, lim - 1)) * 64'(PAGE_BYTES);
      if ($urandom_range(0, 1) == 1) begin
        addr += 64'($urandom_range(0, PAGE_BYTES - 1));
      end
    end else begin
      case ($urandom_range(0, 3))
        0: addr = '0;
        1: addr = model_base - 64'($urandom_range(1, 3 * PAGE_BYTES));
        2: addr = model_base + 64'(lim) * 64'(PAGE_BYTES)
                  + 64'($urandom_range(0, 3 * PAGE_BYTES));
        default: ;  // keep the fully random address
      endcase
    end
    send_request(op, addr);
  endtask

  // Random bursts with random gaps; one full drain midway
  task automatic run_traffic(int unsigned n_items);
    int unsigned sent;
    int unsigned burst;
    bit          paused;
    sent   = 0;
    paused = 1'b0;
    while (sent < n_items) begin
      burst = $urandom_range(1, 24);
      for (int j = 0; j < burst && sent < n_items; j++) begin
        send_random_request();
        sent++;
      end
      if (!paused && sent >= n_items / 2) begin
        drain_replies();
        paused = 1'b1;
      end else if ($urandom_range(0, 9) >= 3) begin
        hold_off($urandom_range(0, 10));
      end
    end
  endtask

  // Register defaults: no pages managed
  task automatic test_reset_state();
    send_request(OP_ALLOC, {$urandom, $urandom});
    send_request(OP_FREE, '0);
    send_request(OP_FREE, '1);
    configure(64'h0000_0000_8000_0000, '0);
    send_request(OP_FREE, 64'h0000_0000_8000_0000);
    send_request(OP_ALLOC, '0);
  endtask

  // Base zero, page count above the map depth
  task automatic test_identity_map();
    configure('0, '1);
    send_request(OP_FREE, '0);
    send_request(OP_FREE, 64'(PAGE_BYTES));
    send_request(OP_FREE, 64'(NUM_PAGES - 1) * 64'(PAGE_BYTES) + 64'(PAGE_BYTES) - 64'd1);
    send_request(OP_FREE, 64'(NUM_PAGES) * 64'(PAGE_BYTES));
    send_request(OP_FREE, '1);
    send_request(OP_FREE, 64'(PAGE_BYTES) + 64'd7);
    send_request(OP_ALLOC, '0);
    send_request(OP_ALLOC, '1);
    send_request(OP_ALLOC, '0);
  endtask

  // Managed range that runs past the top of the address space
  task automatic test_address_wrap();
    logic [63:0] base;
    base = 64'hFFFF_FFFF_FFFF_E000;
    configure(base, PCOUNT_W'(4));
    send_request(OP_FREE, base);
    send_request(OP_FREE, base + 64'(PAGE_BYTES) + 64'd1);
    send_request(OP_FREE, 64'(PAGE_BYTES));
    send_request(OP_FREE, base - 64'd1);
    send_request(OP_ALLOC, '0);
    send_request(OP_ALLOC, '0);
    send_request(OP_ALLOC, '0);
  endtask

  task automatic test_random_traffic();
    logic [63:0] page_mask;
    page_mask = ~64'(PAGE_BYTES - 1);
    configure('0, PCOUNT_W'(NUM_PAGES));
    run_traffic(PHASE_ITEMS);
    configure({$urandom, $urandom} & page_mask, PCOUNT_W'($urandom_range(1, 64)));
    run_traffic(PHASE_ITEMS);
    configure(64'hFFFF_FFFF_FFFF_F000 - 64'($urandom_range(0, 31)) * 64'(PAGE_BYTES),
              PCOUNT_W'($urandom_range(16, 128)));
    run_traffic(PHASE_ITEMS);
    configure({$urandom, $urandom}, PCOUNT_W'($urandom_range(65, 700)));
    run_traffic(PHASE_ITEMS);
    configure({$urandom, $urandom} & page_mask, '1);
    run_traffic(PHASE_ITEMS);
    configure('0, PCOUNT_W'($urandom_range(1, 8)));
    run_traffic(PHASE_ITEMS);
  endtask

  initial begin
    foreach (frame_used[i]) frame_used[i] = 1'b1;
    model_base   = '0;
    model_count  = '0;
    rst_n        = 1'b0;
    psel         = 1'b0;
    penable      = 1'b0;
    pwrite       = 1'b0;
    paddr        = '0;
    pwdata       = '0;
    start        = 1'b0;
    in_op        = OP_ALLOC;
    in_page_addr = '0;
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_reset_state();
    test_identity_map();
    test_address_wrap();
    test_random_traffic();

    drain_replies();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("summary: %0d requests over ten register settings, %0d errors",
             requests_sent, mismatches);
    $display("summary: replies ok %0d, exhausted %0d, null free %0d, out of range %0d",
             status_seen[ST_OK], status_seen[ST_EXHAUSTED], status_seen[ST_NULL],
             status_seen[ST_RANGE]);
    if (mismatches == 0 && expected_replies.size() == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule

[sim.f]
+incdir+hdl
hdl/bpa_pkg.sv
hdl/bpa_ram.sv
hdl/bpa_addsub.sv
hdl/bpa_cfg.sv
hdl/bitmap_page_allocator_top.sv
dv/tb.sv
